// ===== sv/qspb_pkg.sv =====
// Package: shared types, constants and codes of the shortest path block.
`timescale 1ns / 1ps
package qspb_pkg;
   localparam int MaxNodes   = 64;
   localparam int MaxEdges   = 256;
   localparam int NodeBits   = 6;
   localparam int CountBits  = 7;
   localparam int EdgeAddrBits = 8;
   localparam int EdgeCntBits  = 9;
   localparam int WeightBits = 16;
   localparam int CostBits   = 22;
   localparam logic [CostBits-1:0] CostMax = {CostBits{1'b1}};
   localparam logic [NodeBits-1:0] HopMax = {NodeBits{1'b1}};

   typedef enum logic [1:0] {
      CMD_ADD_EDGE = 2'd0,
      CMD_BLOCK    = 2'd1,
      CMD_RUN      = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_NODE_COUNT   = 1'b0,
      REG_SKIP_BLOCKED = 1'b1
   } reg_idx_type;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_POP, S_POPW, S_ULD, S_EREAD, S_EDGE, S_RELAX,
      S_WSTART, S_WCOST, S_WRD, S_WPRED, S_ORD, S_OLD, S_NF
   } state_type;

   typedef struct packed {
      logic [NodeBits-1:0]   a;
      logic [NodeBits-1:0]   b;
      logic [WeightBits-1:0] w;
   } edge_type;

   typedef struct packed {
      logic [CostBits-1:0] cost;
      logic [NodeBits-1:0] hops;
      logic [NodeBits-1:0] pred;
   } node_type;

   typedef struct packed {
      logic [CountBits-1:0] node_count;
      logic                 skip_blocked;
   } cfg_type;
endpackage

// ===== sv/qspb_if.sv =====
// Interfaces: request, result and register write channels.
`timescale 1ns / 1ps
interface qspb_req_if import qspb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            command;
   logic [NodeBits-1:0]   node_a;
   logic [NodeBits-1:0]   node_b;
   logic [WeightBits-1:0] edge_weight;
   modport source (output valid, command, node_a, node_b, edge_weight, input ready);
   modport sink (input valid, command, node_a, node_b, edge_weight, output ready);
endinterface

interface qspb_rsp_if import qspb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [NodeBits-1:0] path_node;
   logic [CostBits-1:0] total_cost;
   logic [NodeBits-1:0] hop_total;
   logic                found;
   logic                last;
   modport source (output valid, path_node, total_cost, hop_total, found, last,
                   input ready);
   modport sink (input valid, path_node, total_cost, hop_total, found, last,
                 output ready);
endinterface

interface qspb_csr_if import qspb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 index;
   logic [CountBits-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/qspb_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module qspb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

// ===== sv/qspb_engine.sv =====
// Search engine: command decode, SPFA sequencer, path walk and result register.
`timescale 1ns / 1ps
module qspb_engine import qspb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   qspb_req_if.sink    req,
   qspb_rsp_if.source  rsp
);
   state_type state_ff, state_in;

   logic [EdgeCntBits-1:0] edges_ff, edges_in, e_ff, e_in;
   logic [MaxNodes-1:0]    blocked_ff, blocked_in, reached_ff, reached_in;
   logic [MaxNodes-1:0]    queued_ff, queued_in;
   logic [NodeBits-1:0]    u_ff, u_in, head_ff, head_in, node_ff, node_in;
   logic [CountBits-1:0]   count_ff, count_in, k_ff, k_in;
   logic [CostBits-1:0]    cost_u_ff, cost_u_in, tot_ff, tot_in;
   logic [NodeBits-1:0]    hops_u_ff, hops_u_in, hop_ff, hop_in, i_ff, i_in;
   logic [NodeBits-1:0]    v_ff, v_in;
   logic [WeightBits-1:0]  w_ff, w_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NodeBits-1:0]  rsp_node_ff, rsp_node_in, rsp_hop_ff, rsp_hop_in;
   logic [CostBits-1:0]  rsp_cost_ff, rsp_cost_in;
   logic                 rsp_found_ff, rsp_found_in, rsp_last_ff, rsp_last_in;

   // memory ports
   logic                    e_we, e_re, n_we, n_re, q_we, q_re;
   logic [EdgeAddrBits-1:0] e_waddr, e_raddr;
   edge_type                e_wdata, e_rdata;
   logic [NodeBits-1:0]     n_waddr, n_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
   node_type                n_wdata, n_rdata;

   qspb_ram #(.WIDTH($bits(edge_type)), .DEPTH(MaxEdges)) u_edge_ram (
      .clock, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
      .re(e_re), .raddr(e_raddr), .rdata(e_rdata));
   qspb_ram #(.WIDTH($bits(node_type)), .DEPTH(MaxNodes)) u_node_ram (
      .clock, .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
      .re(n_re), .raddr(n_raddr), .rdata(n_rdata));
   // work queue during the search, path buffer during the walk
   qspb_ram #(.WIDTH(NodeBits), .DEPTH(MaxNodes)) u_queue_ram (
      .clock, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .re(q_re), .raddr(q_raddr), .rdata(q_rdata));

   logic                 req_xfer, out_free, e_in_range, e_hit, e_take, e_last;
   logic [NodeBits-1:0]  e_v, dest;
   logic [CostBits:0]    cand_sum;
   logic [CostBits-1:0]  cand;
   logic                 improve;

   assign req.ready   = (state_ff == S_IDLE);
   assign req_xfer    = req.valid && req.ready;
   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign dest        = NodeBits'(cfg.node_count - CountBits'(1));
   assign e_last      = (e_ff + EdgeCntBits'(1)) == edges_ff;

   always_comb begin
      e_in_range = ({1'b0, e_rdata.a} < cfg.node_count) &&
                   ({1'b0, e_rdata.b} < cfg.node_count);
      e_hit = 1'b1;
      e_v   = e_rdata.b;
      priority if (e_rdata.a == u_ff) begin
         e_v = e_rdata.b;
      end else if (e_rdata.b == u_ff) begin
         e_v = e_rdata.a;
      end else begin
         e_hit = 1'b0;
      end
      e_take = e_in_range && e_hit && !(cfg.skip_blocked && blocked_ff[e_v]);
   end

   assign cand_sum = {1'b0, cost_u_ff} + (CostBits+1)'(w_ff);
   assign cand     = cand_sum[CostBits] ? CostMax : cand_sum[CostBits-1:0];
   assign improve  = !reached_ff[v_ff] || (n_rdata.cost > cand);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_xfer && req.command == CMD_RUN) state_in = S_INIT;
         S_INIT:   state_in = S_POP;
         S_POP:    state_in = (count_ff == '0) ? S_WSTART : S_POPW;
         S_POPW:   state_in = S_ULD;
         S_ULD:    state_in = (edges_ff == '0) ? S_POP : S_EREAD;
         S_EREAD:  state_in = S_EDGE;
         S_EDGE: begin
            if (e_take) state_in = S_RELAX;
            else state_in = e_last ? S_POP : S_EREAD;
         end
         S_RELAX:  state_in = e_last ? S_POP : S_EREAD;
         S_WSTART: state_in = S_WCOST;
         S_WCOST:  state_in = reached_ff[dest] ? S_WRD : S_NF;
         S_WRD: begin
            if (node_ff == '0) state_in = S_ORD;
            else if (k_ff == CountBits'(MaxNodes - 1)) state_in = S_NF;
            else state_in = S_WPRED;
         end
         S_WPRED:  state_in = S_WRD;
         S_ORD:    state_in = S_OLD;
         S_OLD:    if (out_free) state_in = (i_ff == hop_ff) ? S_IDLE : S_ORD;
         S_NF:     if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      edges_in = edges_ff;   blocked_in = blocked_ff; reached_in = reached_ff;
      queued_in = queued_ff; e_in = e_ff;  u_in = u_ff; head_in = head_ff;
      count_in = count_ff;   node_in = node_ff; k_in = k_ff; v_in = v_ff;
      cost_u_in = cost_u_ff; hops_u_in = hops_u_ff; tot_in = tot_ff;
      hop_in = hop_ff; i_in = i_ff; w_in = w_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_node_in = rsp_node_ff; rsp_cost_in = rsp_cost_ff; rsp_hop_in = rsp_hop_ff;
      rsp_found_in = rsp_found_ff; rsp_last_in = rsp_last_ff;
      e_we = 1'b0; e_waddr = edges_ff[EdgeAddrBits-1:0];
      e_wdata = '{a: req.node_a, b: req.node_b, w: req.edge_weight};
      e_re = 1'b0; e_raddr = e_ff[EdgeAddrBits-1:0];
      n_we = 1'b0; n_waddr = v_ff; n_wdata = '{cost: cand, hops: hops_u_in, pred: u_ff};
      n_re = 1'b0; n_raddr = e_v;
      q_we = 1'b0; q_waddr = head_ff + count_ff[NodeBits-1:0]; q_wdata = v_ff;
      q_re = 1'b0; q_raddr = head_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               unique case (cmd_type'(req.command))
                  CMD_ADD_EDGE: begin
                     if (edges_ff < EdgeCntBits'(MaxEdges)) begin
                        e_we = 1'b1;
                        edges_in = edges_ff + EdgeCntBits'(1);
                     end
                  end
                  CMD_BLOCK: blocked_in[req.node_a] = 1'b1;
                  CMD_CLEAR: begin
                     edges_in = '0;
                     blocked_in = '0;
                  end
                  CMD_RUN: ;
                  default: ;
               endcase
            end
         end
         S_INIT: begin
            n_we = 1'b1; n_waddr = '0; n_wdata = '0;
            q_we = 1'b1; q_waddr = '0; q_wdata = '0;
            reached_in = MaxNodes'(1); queued_in = MaxNodes'(1);
            head_in = '0; count_in = CountBits'(1);
         end
         S_POP: begin
            if (count_ff != '0) begin
               q_re = 1'b1;
               head_in = head_ff + NodeBits'(1);
               count_in = count_ff - CountBits'(1);
            end
         end
         S_POPW: begin
            u_in = q_rdata;
            queued_in[q_rdata] = 1'b0;
            n_re = 1'b1; n_raddr = q_rdata;
         end
         S_ULD: begin
            cost_u_in = n_rdata.cost;
            hops_u_in = n_rdata.hops;
            e_in = '0;
         end
         S_EREAD: e_re = 1'b1;
         S_EDGE: begin
            v_in = e_v; w_in = e_rdata.w;
            if (e_take) n_re = 1'b1;
            else e_in = e_ff + EdgeCntBits'(1);
         end
         S_RELAX: begin
            hops_u_in = hops_u_ff;
            n_wdata.hops = (hops_u_ff == HopMax) ? HopMax : hops_u_ff + NodeBits'(1);
            if (improve) begin
               n_we = 1'b1;
               reached_in[v_ff] = 1'b1;
               if (!queued_ff[v_ff] && count_ff < CountBits'(MaxNodes)) begin
                  q_we = 1'b1;
                  count_in = count_ff + CountBits'(1);
                  queued_in[v_ff] = 1'b1;
               end
            end
            e_in = e_ff + EdgeCntBits'(1);
         end
         S_WSTART: begin
            n_re = 1'b1; n_raddr = dest;
         end
         S_WCOST: begin
            tot_in = n_rdata.cost;
            node_in = dest; k_in = '0;
         end
         S_WRD: begin
            q_we = 1'b1; q_waddr = k_ff[NodeBits-1:0]; q_wdata = node_ff;
            hop_in = k_ff[NodeBits-1:0]; i_in = '0;
            k_in = k_ff + CountBits'(1);
            n_re = 1'b1; n_raddr = node_ff;
         end
         S_WPRED: node_in = n_rdata.pred;
         S_ORD: begin
            q_re = 1'b1; q_raddr = hop_ff - i_ff;
         end
         S_OLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in = q_rdata; rsp_cost_in = tot_ff; rsp_hop_in = hop_ff;
               rsp_found_in = 1'b1; rsp_last_in = (i_ff == hop_ff);
               i_in = i_ff + NodeBits'(1);
            end
         end
         S_NF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_node_in = '0; rsp_cost_in = '0; rsp_hop_in = '0;
               rsp_found_in = 1'b0; rsp_last_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         edges_ff <= '0;
         blocked_ff <= '0;
         reached_ff <= '0;
         queued_ff <= '0;
         head_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         edges_ff <= edges_in;
         blocked_ff <= blocked_in;
         reached_ff <= reached_in;
         queued_ff <= queued_in;
         head_ff <= head_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_ff <= e_in; u_ff <= u_in; node_ff <= node_in; k_ff <= k_in; v_ff <= v_in;
      w_ff <= w_in; cost_u_ff <= cost_u_in; hops_u_ff <= hops_u_in;
      tot_ff <= tot_in; hop_ff <= hop_in; i_ff <= i_in;
      rsp_node_ff <= rsp_node_in; rsp_cost_ff <= rsp_cost_in; rsp_hop_ff <= rsp_hop_in;
      rsp_found_ff <= rsp_found_in; rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.path_node  = rsp_node_ff;
   assign rsp.total_cost = rsp_cost_ff;
   assign rsp.hop_total  = rsp_hop_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.last       = rsp_last_ff;
endmodule

// ===== sv/queue_shortest_path_with_blocked_nodes.sv =====
// Top level: register file and search engine.
//
//  channel  dir  payload                                      transfer
//  req_ch   in   command, node_a, node_b, edge_weight         valid & ready
//  rsp_ch   out  path_node, total_cost, hop_total, found, last valid & ready
//  csr_ch   in   index, data                                  valid & ready
//
// Add edge, block and clear are taken in idle. A run pops each queued node,
// reads its node record, then each stored edge, relaxing the taken ones,
// then walks the predecessors back from the destination, one result per
// path node. Reset is synchronous; edge and node RAMs need no clearing.
// A stalled result holds in the output register; new items wait in idle.
`timescale 1ns / 1ps
module queue_shortest_path_with_blocked_nodes import qspb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   qspb_req_if.sink   req_ch,
   qspb_rsp_if.source rsp_ch,
   qspb_csr_if.sink   csr_ch
);
   cfg_type cfg_ff, cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (reg_idx_type'(csr_ch.index))
            REG_NODE_COUNT: begin
               priority if (csr_ch.data < CountBits'(2)) cfg_in.node_count = CountBits'(2);
               else if (csr_ch.data > CountBits'(MaxNodes))
                  cfg_in.node_count = CountBits'(MaxNodes);
               else cfg_in.node_count = csr_ch.data;
            end
            REG_SKIP_BLOCKED: cfg_in.skip_blocked = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{node_count: CountBits'(MaxNodes), skip_blocked: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qspb_engine u_engine (
      .clock, .reset, .cfg(cfg_ff), .req(req_ch), .rsp(rsp_ch));
endmodule

// ===== sv/qspb_check.sv =====
// Port checker for the shortest path block, bound to the top level.
`timescale 1ns / 1ps
module qspb_check import qspb_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [NodeBits-1:0] rsp_path_node,
   input logic [NodeBits-1:0] rsp_hop_total,
   input logic                rsp_found,
   input logic                rsp_last
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_path_node))
      else $error("result changed under stall");

   a_nf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_path_node == '0 && rsp_hop_total == '0)
      else $error("malformed not-found result");

   a_hops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_hop_total != '0)
      else $error("found path without edges");

   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last ##1 rsp_valid && rsp_found
      |-> rsp_path_node == '0)
      else $error("path does not start at source");
endmodule

bind queue_shortest_path_with_blocked_nodes qspb_check u_check (
   .clock, .reset,
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_path_node(rsp_ch.path_node), .rsp_hop_total(rsp_ch.hop_total),
   .rsp_found(rsp_ch.found), .rsp_last(rsp_ch.last));

// ===== tb/testbench.sv =====
// Testbench: shortest path block driven with edge loads, blocks, clears and runs.
`timescale 1ns / 1ps
module testbench import qspb_pkg::*; ();

   localparam int CycleLimit = 3000000;

   typedef struct {
      logic [NodeBits-1:0] node;
      logic [CostBits-1:0] cost;
      logic [NodeBits-1:0] hops;
      logic                found;
      logic                last;
   } path_step_type;

   class path_scoreboard;
      logic [NodeBits-1:0]   edge_a [MaxEdges];
      logic [NodeBits-1:0]   edge_b [MaxEdges];
      logic [WeightBits-1:0] edge_w [MaxEdges];
      int                    edge_total;
      logic [MaxNodes-1:0]   blocked;
      int                    nodes_used;
      bit                    skip_blk;
      int                    cost_to [MaxNodes];
      int                    hop_of [MaxNodes];
      int                    via [MaxNodes];
      logic [MaxNodes-1:0]   reached, queued;
      int                    fifo [$];
      path_step_type         expected_steps [$];
      int                    errors;
      int                    checked;
      int                    runs, misses;

      function new();
         edge_total = 0;
         blocked = '0;
         nodes_used = MaxNodes;
         skip_blk = 0;
         errors = 0;
         checked = 0;
         runs = 0;
         misses = 0;
      endfunction

      function void write_reg(reg_idx_type idx, int value);
         int v;
         v = value & 127;
         if (idx == REG_NODE_COUNT) begin
            if (v < 2) v = 2;
            if (v > MaxNodes) v = MaxNodes;
            nodes_used = v;
         end else begin
            skip_blk = bit'(value & 1);
         end
      endfunction

      function void relax(int u, int v, int w);
         int cand;
         if (skip_blk && blocked[v]) return;
         cand = cost_to[u] + w;
         if (cand > int'(CostMax)) cand = int'(CostMax);
         if (reached[v] && cost_to[v] <= cand) return;
         cost_to[v] = cand;
         hop_of[v] = (hop_of[u] >= 63) ? 63 : hop_of[u] + 1;
         via[v] = u;
         reached[v] = 1'b1;
         if (!queued[v]) begin
            fifo = {fifo, v};
            queued[v] = 1'b1;
         end
      endfunction

      function void search_and_predict();
         int u, a, b, dest, node, k;
         int trail [$];
         bit ok;
         path_step_type s;
         foreach (cost_to[i]) begin
            cost_to[i] = 0;
            hop_of[i] = 0;
         end
         reached = 1;
         queued = 1;
         fifo = {0};
         while (fifo.size() > 0) begin
            u = fifo.pop_front();
            queued[u] = 1'b0;
            for (int e = 0; e < edge_total; e++) begin
               a = edge_a[e];
               b = edge_b[e];
               if (a >= nodes_used || b >= nodes_used) continue;
               if (a == u) relax(u, b, edge_w[e]);
               if (b == u) relax(u, a, edge_w[e]);
            end
         end
         dest = nodes_used - 1;
         ok = 0;
         runs++;
         if (reached[dest]) begin
            node = dest;
            while (trail.size() < MaxNodes) begin
               trail.push_front(node);
               if (node == 0) begin
                  ok = 1;
                  break;
               end
               node = via[node];
            end
         end
         if (!ok) begin
            misses++;
            s = '{node: 0, cost: 0, hops: 0, found: 0, last: 1};
            expected_steps = {expected_steps, s};
            return;
         end
         k = trail.size();
         for (int i = 0; i < k; i++) begin
            s.node = NodeBits'(trail[i]);
            s.cost = CostBits'(cost_to[dest]);
            s.hops = NodeBits'(k - 1);
            s.found = 1'b1;
            s.last = (i + 1 == k);
            expected_steps = {expected_steps, s};
         end
      endfunction

      function void note_request(cmd_type cmd, logic [NodeBits-1:0] a,
                                 logic [NodeBits-1:0] b, logic [WeightBits-1:0] w);
         unique case (cmd)
            CMD_ADD_EDGE: begin
               if (edge_total < MaxEdges) begin
                  edge_a[edge_total] = a;
                  edge_b[edge_total] = b;
                  edge_w[edge_total] = w;
                  edge_total++;
               end
            end
            CMD_BLOCK: blocked[a] = 1'b1;
            CMD_CLEAR: begin
               edge_total = 0;
               blocked = '0;
            end
            CMD_RUN: search_and_predict();
            default: ;
         endcase
      endfunction

      function void check_result(path_step_type got);
         path_step_type want;
         checked++;
         if (expected_steps.size() == 0) begin
            $error("unexpected result: node %0d cost %0d", got.node, got.cost);
            errors++;
            return;
         end
         want = expected_steps.pop_front();
         if (got.node !== want.node) begin
            $error("path_node: expected %0d, got %0d", want.node, got.node);
            errors++;
         end
         if (got.cost !== want.cost) begin
            $error("total_cost: expected %0d, got %0d", want.cost, got.cost);
            errors++;
         end
         if (got.hops !== want.hops) begin
            $error("hop_total: expected %0d, got %0d", want.hops, got.hops);
            errors++;
         end
         if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   qspb_req_if req_ch ();
   qspb_rsp_if rsp_ch ();
   qspb_csr_if csr_ch ();

   queue_shortest_path_with_blocked_nodes DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   path_scoreboard sb = new();
   bit calm = 0;
   bit hold_request = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int cycles = 0;
   int sent_items = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: check each transfer, stall in bursts, long hold on request
   initial begin
      int stall;
      path_step_type got;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.node = rsp_ch.path_node;
            got.cost = rsp_ch.total_cost;
            got.hops = rsp_ch.hop_total;
            got.found = rsp_ch.found;
            got.last = rsp_ch.last;
            sb.check_result(got);
         end
         if (hold_request) begin
            hold_request = 0;
            stall = 600;
         end
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall = $urandom_range(1, 11) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send(cmd_type cmd, int a = 0, int b = 0, int w = 0);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.node_a <= NodeBits'(a);
      req_ch.node_b <= NodeBits'(b);
      req_ch.edge_weight <= WeightBits'(w);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(cmd, NodeBits'(a), NodeBits'(b), WeightBits'(w));
      sent_items++;
   endtask

   // stop offering and let every pending path drain
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_steps.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= CountBits'(value);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.write_reg(idx, value);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase();
      int nc, pick, edges, hi;
      pick = $urandom_range(0, 9);
      if (pick < 6) nc = $urandom_range(2, 12);
      else if (pick < 8) nc = $urandom_range(13, 40);
      else if (pick < 9) nc = 64;
      else nc = $urandom_range(0, 127);
      write_reg(REG_NODE_COUNT, nc);
      write_reg(REG_SKIP_BLOCKED, $urandom_range(0, 1));
      hi = sb.nodes_used - 1;
      gap_pct = $urandom_range(0, 2) * 20;
      stall_pct = $urandom_range(0, 2) * 15;
      send(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      edges = $urandom_range(1, 16);
      for (int i = 0; i < edges; i++) begin
         if ($urandom_range(0, 7) == 0)
            send(CMD_ADD_EDGE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
         else if ($urandom_range(0, 3) == 0)
            send(CMD_ADD_EDGE, $urandom_range(0, hi), $urandom_range(0, hi),
                 $urandom_range(0, 15));
         else
            send(CMD_ADD_EDGE, $urandom_range(0, hi), $urandom_range(0, hi), $urandom);
         if ($urandom_range(0, 9) == 0) begin
            send(CMD_BLOCK, $urandom_range(0, hi), $urandom_range(0, 63), $urandom);
         end
         if ($urandom_range(0, 7) == 0) begin
            send(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
         end
      end
      repeat ($urandom_range(1, 3)) begin
         send(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      end
      drain();
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_ADD_EDGE;
      req_ch.node_a <= '0;
      req_ch.node_b <= '0;
      req_ch.edge_weight <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= REG_NODE_COUNT;
      csr_ch.data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (5) @(posedge clock);

      // directed: smallest graph, weight extremes, empty graph
      write_reg(REG_NODE_COUNT, 2);
      send(CMD_ADD_EDGE, 0, 1, 16'hFFFF);
      send(CMD_RUN);
      send(CMD_ADD_EDGE, 1, 0, 0);
      send(CMD_RUN);
      send(CMD_CLEAR);
      send(CMD_RUN);
      drain();
      write_reg(REG_NODE_COUNT, 0);
      send(CMD_ADD_EDGE, 1, 1, 5);
      send(CMD_RUN);
      drain();
      // blocked destination with skipping, then blocked source without it
      write_reg(REG_NODE_COUNT, 127);
      write_reg(REG_SKIP_BLOCKED, 1);
      send(CMD_ADD_EDGE, 0, 63, 16'hFFFF);
      send(CMD_ADD_EDGE, 63, 63, 16'h5555);
      send(CMD_BLOCK, 63, 63, 16'hAAAA);
      send(CMD_RUN, 63, 63, 16'hFFFF);
      drain();
      write_reg(REG_SKIP_BLOCKED, 0);
      send(CMD_BLOCK, 0);
      send(CMD_RUN);
      drain();
      // edge past the node count is ignored by the search
      write_reg(REG_NODE_COUNT, 4);
      send(CMD_CLEAR);
      send(CMD_ADD_EDGE, 0, 5, 1);
      send(CMD_ADD_EDGE, 5, 3, 1);
      send(CMD_ADD_EDGE, 0, 3, 9);
      send(CMD_ADD_EDGE, 0, 2, 2);
      send(CMD_ADD_EDGE, 2, 3, 3);
      send(CMD_RUN);
      drain();

      // long chain: one result per node, then overfill the edge store
      write_reg(REG_NODE_COUNT, 64);
      send(CMD_CLEAR);
      for (int i = 0; i < 63; i++) send(CMD_ADD_EDGE, i, i + 1, 16'hFFFF);
      send(CMD_RUN);
      drain();
      write_reg(REG_NODE_COUNT, 3);
      gap_pct = 10;
      for (int i = 0; i < 196; i++)
         send(CMD_ADD_EDGE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      send(CMD_ADD_EDGE, 0, 2, 7);
      send(CMD_RUN);
      drain();
      gap_pct = 0;

      // hold results back while runs keep coming, so the input backs up
      write_reg(REG_NODE_COUNT, 8);
      send(CMD_CLEAR);
      for (int i = 0; i < 7; i++) send(CMD_ADD_EDGE, i, i + 1, $urandom_range(0, 99));
      hold_request = 1;
      repeat (6) send(CMD_RUN);
      drain();

      while (sent_items < 380) begin
         if (sent_items > 330) calm = 1;
         random_phase();
      end

      drain();
      $display("covered %0d runs (%0d without a path), %0d results checked",
               sb.runs, sb.misses, sb.checked);
      if (sb.errors == 0 && sb.expected_steps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
